// File: sv/e10f_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and single-precision arithmetic functions for the exp10 unit.
package e10f_pkg;

  // Single-precision bit patterns of the constants used by the datapath.
  localparam logic [31:0] F_ONE     = 32'h3F800000;
  localparam logic [31:0] F_HALF    = 32'h3F000000;
  localparam logic [31:0] F_TWO     = 32'h40000000;
  localparam logic [31:0] F_INF     = 32'h7F800000;
  localparam logic [31:0] F_LIMIT   = 32'h4218EC59;
  localparam logic [31:0] F_LOG2_10 = 32'h40549A78;
  localparam logic [31:0] F_LOG10_2 = 32'h3E9A209B;
  localparam logic [31:0] F_C0      = 32'h3D27EBB0;
  localparam logic [31:0] F_C1      = 32'h413BECA4;
  localparam logic [31:0] F_C2      = 32'h43CB5BD0;
  localparam logic [31:0] F_C3      = 32'h4515A3CC;
  localparam logic [31:0] F_D0      = 32'h42AA2FEE;
  localparam logic [31:0] F_D1      = 32'h449F02F7;
  localparam logic [31:0] F_D2      = 32'h4501F9BB;

  // Divider organization: quotient bits retired per stage and number of step stages.
  localparam int DIV_STEPS_PER_STAGE = 4;
  localparam int DIV_STEP_STAGES     = 7;
  localparam int DIV_QW              = DIV_STEPS_PER_STAGE * DIV_STEP_STAGES;
  localparam int DIV_LAT             = DIV_STEP_STAGES + 2;

  typedef logic signed [11:0] fexp_t;
  typedef logic [49:0]        fman_t;

  // Data that rides alongside the arithmetic to the final stage.
  typedef struct packed {
    logic        spec;
    logic [31:0] sval;
    logic [7:0]  ebits;
  } side_t;

  function automatic logic [5:0] lzc50(input fman_t m);
    logic [5:0] n;
    logic       found;
    n     = 6'd50;
    found = 1'b0;
    for (int i = 49; i >= 0; i--) begin
      if (!found && m[i]) begin
        n     = 6'(49 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic fexp_t eff_exp(input logic [31:0] a);
    return (a[30:23] == 8'd0) ? 12'sd1 : fexp_t'({4'b0, a[30:23]});
  endfunction

  function automatic logic [23:0] mant24(input logic [31:0] a);
    return {a[30:23] != 8'd0, a[22:0]};
  endfunction

  // Normalizes and rounds (nearest even). When m[49] is set, e is the biased exponent.
  function automatic logic [31:0] fp_pack(input logic s, input fexp_t e, input fman_t m);
    logic [5:0]  lz;
    fman_t       mn;
    fexp_t       en;
    logic [5:0]  sh;
    fman_t       lost;
    logic [22:0] frac;
    logic        g;
    logic        st;
    logic [30:0] mag;
    logic [31:0] res;
    lz = lzc50(m);
    mn = m << lz;
    en = e - fexp_t'({6'b0, lz});
    if (en <= 12'sd0) begin
      sh   = (en < -12'sd48) ? 6'd50 : 6'(12'sd1 - en);
      lost = mn & ~({50{1'b1}} << sh);
      mn   = (mn >> sh) | {49'b0, |lost};
      en   = 12'sd0;
    end
    frac = mn[48:26];
    g    = mn[25];
    st   = |mn[24:0];
    mag  = {en[7:0], frac} + 31'(g & (st | frac[0]));
    if (m == '0) begin
      res = {s, 31'b0};
    end else if (en >= 12'sd255) begin
      res = {s, F_INF[30:0]};
    end else begin
      res = {s, mag};
    end
    return res;
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic [47:0] p;
    fexp_t       e;
    p = mant24(a) * mant24(b);
    e = eff_exp(a) + eff_exp(b) - 12'sd126;
    return fp_pack(a[31] ^ b[31], e, {p, 2'b0});
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] big;
    logic [31:0] sml;
    fexp_t       d;
    logic [5:0]  sh;
    fman_t       mb;
    fman_t       ms;
    fman_t       lost;
    fman_t       sum;
    logic        s;
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    d    = eff_exp(big) - eff_exp(sml);
    sh   = (d > 12'sd50) ? 6'd50 : 6'(d);
    mb   = {1'b0, mant24(big), 25'b0};
    ms   = {1'b0, mant24(sml), 25'b0};
    lost = ms & ~({50{1'b1}} << sh);
    ms   = (ms >> sh) | {49'b0, |lost};
    if (big[31] == sml[31]) begin
      sum = mb + ms;
    end else begin
      sum = mb - ms;
    end
    s = (sum == '0 && big[31] != sml[31]) ? 1'b0 : big[31];
    return fp_pack(s, eff_exp(big) + 12'sd1, sum);
  endfunction

  function automatic logic [31:0] fsub(input logic [31:0] a, input logic [31:0] b);
    return fadd(a, {~b[31], b[30:0]});
  endfunction

  // Floor of a value whose magnitude is below 256.
  function automatic logic signed [9:0] floor_f(input logic [31:0] t);
    logic [23:0] m;
    logic [2:0]  k;
    logic [4:0]  sh;
    logic [9:0]  ip;
    logic        fnz;
    logic [9:0]  res;
    m = mant24(t);
    if (t[30:23] < 8'd127) begin
      ip  = 10'd0;
      fnz = (t[30:0] != 31'd0);
    end else begin
      k   = (t[30:23] > 8'd134) ? 3'd7 : 3'(t[30:23] - 8'd127);
      sh  = 5'd23 - {2'b0, k};
      ip  = 10'(m >> sh);
      fnz = |(m & ~(24'hFFFFFF << sh));
    end
    res = t[31] ? (10'd0 - (ip + {9'b0, fnz})) : ip;
    return res;
  endfunction

  function automatic logic [31:0] int2f(input logic signed [9:0] n);
    logic [9:0] mag;
    mag = n[9] ? (10'd0 - n) : n;
    return fp_pack(n[9], 12'sd176, {40'b0, mag});
  endfunction

endpackage

// File: sv/exp10_float32_unit.sv
`timescale 1ns / 1ps
// Top level of the fully pipelined single-precision ten-to-the-power-x unit.
//
//   Channel   Ports                          Transfer
//   --------  -----------------------------  ------------------------------------------
//   input     start, busy, in_arg_bits       edge with start high and busy low
//   result    out_valid, out_result_bits     edge that ends the one-cycle out_valid strobe
//
// The unit takes one argument every clock cycle; busy stays low.
// Each result passes through 14 arithmetic stages, 9 divider stages (one unpack stage,
// seven stages of four quotient bits, one rounding stage), the final add stage and the
// output register.
// Reset is synchronous and active low; it clears only the valid bits of the pipeline.
// The receiver cannot stall, so the pipeline never holds; results leave in transfer order.
module exp10_float32_unit import e10f_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_arg_bits,
  output logic        out_valid,
  output logic [31:0] out_result_bits
);

  // Number of arithmetic stages in front of the divider.
  localparam int NST = 14;
  localparam int LAT = NST + DIV_LAT + 2;

  // Per-item working set. The t field holds log2(10)*x, then t+0.5, then n*log10(2),
  // and finally twice the numerator polynomial; qx ends up holding Q-P.
  typedef struct packed {
    side_t       side;
    logic [31:0] x;
    logic [31:0] t;
    logic [31:0] nf;
    logic [31:0] fr;
    logic [31:0] sq;
    logic [31:0] px;
    logic [31:0] qx;
  } pipe_t;

  logic  in_fire;
  logic  vld_r [1:NST];
  pipe_t st_r  [1:NST];
  pipe_t st_nxt[1:NST];

  logic        div_vld;
  logic [31:0] div_quo;
  side_t       div_side;

  logic        va_r;
  logic [31:0] vala_r;
  logic [31:0] vala_nxt;
  side_t       sidea_r;

  logic        out_valid_r;
  logic [31:0] out_result_bits_r;
  logic [31:0] out_result_bits_nxt;

  // Every cycle is open for a new argument.
  assign busy    = 1'b0;
  assign in_fire = start & ~busy;

  // Stage arithmetic. Every stage performs at most one multiply and one add, each rounded
  // on its own, in the same order as the defining computation.
  always_comb begin
    logic signed [9:0] n3;

    // Stage 1: screen the special arguments, then scale by log2(10).
    st_nxt[1]            = '0;
    st_nxt[1].x          = in_arg_bits;
    st_nxt[1].side.sval  = in_arg_bits;
    if (in_arg_bits[30:0] == 31'd0) begin
      // A zero of either sign gives exactly one.
      st_nxt[1].side.spec = 1'b1;
      st_nxt[1].side.sval = F_ONE;
    end else if (in_arg_bits[30:0] > F_INF[30:0]) begin
      // Not-a-number passes through unchanged.
      st_nxt[1].side.spec = 1'b1;
    end else if (in_arg_bits[30:0] >= F_LIMIT[30:0]) begin
      // Beyond the range limit the result saturates to zero or infinity.
      st_nxt[1].side.spec = 1'b1;
      st_nxt[1].side.sval = in_arg_bits[31] ? 32'd0 : F_INF;
    end
    st_nxt[1].t = fmul(in_arg_bits, F_LOG2_10);

    // Stage 2: add one half ahead of the floor.
    st_nxt[2]   = st_r[1];
    st_nxt[2].t = fadd(st_r[1].t, F_HALF);

    // Stage 3: integer power of two, its float image and the scale exponent field.
    st_nxt[3]            = st_r[2];
    n3                   = floor_f(st_r[2].t);
    st_nxt[3].nf         = int2f(n3);
    st_nxt[3].side.ebits = 8'(n3 + 10'sd127);

    // Stage 4: n times log10(2).
    st_nxt[4]   = st_r[3];
    st_nxt[4].t = fmul(st_r[3].nf, F_LOG10_2);

    // Stage 5: reduced argument.
    st_nxt[5]    = st_r[4];
    st_nxt[5].fr = fsub(st_r[4].x, st_r[4].t);

    // Stage 6: its square.
    st_nxt[6]    = st_r[5];
    st_nxt[6].sq = fmul(st_r[5].fr, st_r[5].fr);

    // Stages 7 to 13: numerator and denominator polynomials evaluated side by side.
    st_nxt[7]    = st_r[6];
    st_nxt[7].px = fmul(F_C0, st_r[6].sq);
    st_nxt[7].qx = fadd(st_r[6].sq, F_D0);

    st_nxt[8]    = st_r[7];
    st_nxt[8].px = fadd(st_r[7].px, F_C1);
    st_nxt[8].qx = fmul(st_r[7].qx, st_r[7].sq);

    st_nxt[9]    = st_r[8];
    st_nxt[9].px = fmul(st_r[8].px, st_r[8].sq);
    st_nxt[9].qx = fadd(st_r[8].qx, F_D1);

    st_nxt[10]    = st_r[9];
    st_nxt[10].px = fadd(st_r[9].px, F_C2);
    st_nxt[10].qx = fmul(st_r[9].qx, st_r[9].sq);

    st_nxt[11]    = st_r[10];
    st_nxt[11].px = fmul(st_r[10].px, st_r[10].sq);
    st_nxt[11].qx = fadd(st_r[10].qx, F_D2);

    st_nxt[12]    = st_r[11];
    st_nxt[12].px = fadd(st_r[11].px, F_C3);

    st_nxt[13]    = st_r[12];
    st_nxt[13].px = fmul(st_r[12].px, st_r[12].fr);

    // Stage 14: divider operands, 2P over Q-P.
    st_nxt[14]    = st_r[13];
    st_nxt[14].t  = fmul(F_TWO, st_r[13].px);
    st_nxt[14].qx = fsub(st_r[13].qx, st_r[13].px);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= NST; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      vld_r[1] <= in_fire;
      for (int k = 2; k <= NST; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= NST; k++) begin
      st_r[k] <= st_nxt[k];
    end
  end

  e10f_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld_r[NST]),
    .num      (st_r[NST].t),
    .den      (st_r[NST].qx),
    .in_side  (st_r[NST].side),
    .out_vld  (div_vld),
    .quo      (div_quo),
    .out_side (div_side)
  );

  // One plus the ratio.
  assign vala_nxt = fadd(F_ONE, div_quo);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    vala_r  <= vala_nxt;
    sidea_r <= div_side;
  end

  // Scale by the power of two made from the exponent field, or pick the special result.
  // An exponent field of zero yields a zero scale word and therefore a zero result.
  assign out_result_bits_nxt = sidea_r.spec ? sidea_r.sval
                             : fmul({1'b0, sidea_r.ebits, 23'b0}, vala_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    out_result_bits_r <= out_result_bits_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_result_bits = out_result_bits_r;

`ifndef SYNTHESIS
  a_out_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(div_vld, 2))
    else $error("result strobe without a divider result two cycles earlier");

  a_zero_gives_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_arg_bits[30:0] == 31'd0) |->
      ##LAT (!out_valid || out_result_bits == F_ONE))
    else $error("zero argument did not give one");

  a_nan_passes: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_arg_bits[30:0] > F_INF[30:0]) |->
      ##LAT (!out_valid || out_result_bits == $past(in_arg_bits, LAT)))
    else $error("NaN argument was not passed through");

  a_sign_only_nan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_bits[31] |-> (out_result_bits[30:23] == 8'hFF))
    else $error("negative result that is not a NaN");
`endif

endmodule

// File: sv/e10f_div.sv
`timescale 1ns / 1ps
// Pipelined single-precision divider, restoring, four quotient bits per stage.
module e10f_div import e10f_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [31:0] num,
  input  logic [31:0] den,
  input  side_t       in_side,
  output logic        out_vld,
  output logic [31:0] quo,
  output side_t       out_side
);

  localparam int NS = DIV_STEP_STAGES;

  logic              vld_r  [0:NS];
  logic              s_r    [0:NS];
  fexp_t             e_r    [0:NS];
  logic [23:0]       mb_r   [0:NS];
  logic [24:0]       rem_r  [0:NS];
  logic [DIV_QW-1:0] q_r    [0:NS];
  side_t             side_r [0:NS];

  logic        s_nxt;
  fexp_t       e_nxt;
  logic [23:0] ma_nxt;
  logic [23:0] mb_nxt;
  logic        out_vld_r;
  logic [31:0] quo_r;
  logic [31:0] quo_nxt;
  side_t       out_side_r;

  // Unpack both operands and bring subnormal significands to a leading one.
  always_comb begin
    logic [5:0] lza;
    logic [5:0] lzb;
    lza    = lzc50({mant24(num), 26'b0});
    lzb    = lzc50({mant24(den), 26'b0});
    ma_nxt = mant24(num) << lza;
    mb_nxt = mant24(den) << lzb;
    s_nxt  = num[31] ^ den[31];
    e_nxt  = (eff_exp(num) - fexp_t'({6'b0, lza})) - (eff_exp(den) - fexp_t'({6'b0, lzb}))
             + 12'sd127;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    s_r[0]    <= s_nxt;
    e_r[0]    <= e_nxt;
    mb_r[0]   <= mb_nxt;
    rem_r[0]  <= {1'b0, ma_nxt};
    q_r[0]    <= '0;
    side_r[0] <= in_side;
  end

  for (genvar k = 1; k <= NS; k++) begin : g_step
    logic [24:0]       rem_nxt;
    logic [DIV_QW-1:0] q_nxt;

    always_comb begin
      rem_nxt = rem_r[k-1];
      q_nxt   = q_r[k-1];
      for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
        q_nxt = {q_nxt[DIV_QW-2:0], rem_nxt >= {1'b0, mb_r[k-1]}};
        if (q_nxt[0]) begin
          rem_nxt = rem_nxt - {1'b0, mb_r[k-1]};
        end
        rem_nxt = {rem_nxt[23:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      s_r[k]    <= s_r[k-1];
      e_r[k]    <= e_r[k-1];
      mb_r[k]   <= mb_r[k-1];
      rem_r[k]  <= rem_nxt;
      q_r[k]    <= q_nxt;
      side_r[k] <= side_r[k-1];
    end
  end

  // The remainder being nonzero is the sticky bit below the quotient.
  assign quo_nxt = fp_pack(s_r[NS], e_r[NS],
                           {q_r[NS], |rem_r[NS], {(49 - DIV_QW){1'b0}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    quo_r      <= quo_nxt;
    out_side_r <= side_r[NS];
  end

  assign out_vld  = out_vld_r;
  assign quo      = quo_r;
  assign out_side = out_side_r;

endmodule
